// ----- hdl/line_line_closest_approach_3d_assert.svh -----
// ----------------------------------------------------------------------------
// Closest approach assertion macros
// Clocked implication checks, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_CLOSEST_APPROACH_3D_ASSERT_SVH
`define LINE_LINE_CLOSEST_APPROACH_3D_ASSERT_SVH

// same-cycle implication
`define LLCA_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("llca check failed");

// next-cycle implication
`define LLCA_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("llca check failed");

`endif

// ----- hdl/llca_pkg.sv -----
// ----------------------------------------------------------------------------
// Closest approach package
// Request and result types, status codes and pipeline latencies.
// ----------------------------------------------------------------------------
package llca_pkg;

	typedef struct packed {
		logic signed [31:0] first_base_x;
		logic signed [31:0] first_base_y;
		logic signed [31:0] first_base_z;
		logic signed [31:0] first_dir_x;
		logic signed [31:0] first_dir_y;
		logic signed [31:0] first_dir_z;
		logic signed [31:0] second_base_x;
		logic signed [31:0] second_base_y;
		logic signed [31:0] second_base_z;
		logic signed [31:0] second_dir_x;
		logic signed [31:0] second_dir_y;
		logic signed [31:0] second_dir_z;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        gap_distance;
		logic signed [31:0] mid_x;
		logic signed [31:0] mid_y;
		logic signed [31:0] mid_z;
	} res_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DIR2_ZERO = 2'd1;
	localparam logic [1:0] ST_DIR1_ZERO = 2'd2;
	localparam logic [1:0] ST_PARALLEL  = 2'd3;

	localparam int MUL1_LAT  = 1;
	localparam int MUL2_LAT  = 3;
	localparam int MUL3_LAT  = 4;
	localparam int GAP_QW    = 64;
	localparam int DIVQ_LAT  = GAP_QW + 1;
	localparam int SQRT_LAT  = GAP_QW / 2;
	localparam int MID_QW    = 33;
	localparam int MID_LAT   = DIVQ_LAT + SQRT_LAT;

endpackage

// ----- hdl/line_line_closest_approach_3d.sv -----
// ----------------------------------------------------------------------------
// Line to line closest approach in 3D
// Distance and midpoint of the closest points of two lines, Q16.16.
// ----------------------------------------------------------------------------
//   channel   signals                         direction
//   request   req_valid, req_ready, req       in
//   result    res_valid, res_ready, res       out
//   config    cfg_wen, cfg_wdata              in
//
// One request per cycle while the skid register is empty; the distance path runs
// through the 65-stage quotient divider and 32-stage square root in series.
// Reset clears all valid bits, including the skid valid flag, and the threshold.
// A stalled result lands in a one-entry skid register; while it is full the
// whole pipeline holds.
// ----------------------------------------------------------------------------
`include "line_line_closest_approach_3d_assert.svh"

module line_line_closest_approach_3d (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  llca_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output llca_pkg::res_t res,
	input  logic           cfg_wen,
	input  logic [31:0]    cfg_wdata
);

	import llca_pkg::*;

	localparam int S_IN    = 1;
	localparam int S_CROSS = S_IN + MUL1_LAT + 1;
	localparam int S_DOT   = S_CROSS + MUL2_LAT + 1;
	localparam int S_NUM   = S_DOT + MUL3_LAT + 1;
	localparam int S_FMT   = S_NUM + MID_LAT;
	localparam int S_OUT   = S_FMT + 1;

	typedef struct packed {
		logic             z1;
		logic             z2;
		logic [2:0][32:0] w;
		logic [2:0][32:0] bsum;
		logic [2:0][31:0] d1;
		logic [2:0][31:0] d2;
	} side_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] neg;
	} tail_t;

	logic               adv;
	logic [31:0]        thr_q;
	logic [S_OUT:S_IN]  vld_s;
	side_t              side_in;
	side_t              side_s [S_IN:S_NUM-1];
	tail_t              tail_s [S_NUM:S_FMT];
	logic               skid_v_q;
	res_t               skid_q;
	res_t               out_s110;
	res_t               out_nxt;

	logic signed [63:0]  pca [3];
	logic signed [63:0]  pcb [3];
	logic signed [64:0]  p1a [3];
	logic signed [64:0]  p1b [3];
	logic signed [64:0]  p2a [3];
	logic signed [64:0]  p2b [3];
	logic signed [64:0]  c_s3  [3];
	logic signed [65:0]  t1_s3 [3];
	logic signed [65:0]  t2_s3 [3];

	logic signed [129:0] pden [3];
	logic signed [130:0] pta  [3];
	logic signed [130:0] ptb  [3];
	logic signed [97:0]  pwc  [3];
	logic [131:0]        den_s [S_DOT:S_NUM-1];
	logic signed [132:0] ta_s7;
	logic signed [132:0] tb_s7;
	logic signed [99:0]  wc_s7;

	logic signed [199:0] pwc2;
	logic signed [164:0] pb  [3];
	logic signed [164:0] pd1 [3];
	logic signed [164:0] pd2 [3];
	logic signed [166:0] num  [3];
	logic signed [166:0] absn [3];
	logic [1:0]          st_nxt;

	logic [198:0]        nq_s12;
	logic [130:0]        dq_s12;
	logic [167:0]        nm_s12 [3];
	logic [132:0]        dm_s12;

	logic [GAP_QW-1:0]   q_gap;
	logic                sat_gap;
	logic [31:0]         gap;
	logic [MID_QW-1:0]   m_mid   [3];
	logic                sat_mid [3];
	logic [31:0]         mres    [3];

	assign adv       = !skid_v_q;
	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[S_OUT-1:S_IN], req_valid};
		end
	end

	always_comb begin
		side_in.d1   = {req.first_dir_z, req.first_dir_y, req.first_dir_x};
		side_in.d2   = {req.second_dir_z, req.second_dir_y, req.second_dir_x};
		side_in.w[0] = 33'(req.second_base_x) - 33'(req.first_base_x);
		side_in.w[1] = 33'(req.second_base_y) - 33'(req.first_base_y);
		side_in.w[2] = 33'(req.second_base_z) - 33'(req.first_base_z);
		side_in.bsum[0] = 33'(req.second_base_x) + 33'(req.first_base_x);
		side_in.bsum[1] = 33'(req.second_base_y) + 33'(req.first_base_y);
		side_in.bsum[2] = 33'(req.second_base_z) + 33'(req.first_base_z);
		side_in.z1 = (req.first_dir_x == '0) && (req.first_dir_y == '0)
			&& (req.first_dir_z == '0);
		side_in.z2 = (req.second_dir_x == '0) && (req.second_dir_y == '0)
			&& (req.second_dir_z == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[S_IN] <= side_in;
			for (int k = S_IN; k < S_NUM - 1; k++) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// cross products: c = d1 x d2, t1 = w x d2, t2 = w x d1
	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;

		llca_mul #(.WA(32), .WB(32), .LAT(MUL1_LAT)) u_ca (
			.clk(clk), .en(adv),
			.a($signed(side_s[S_IN].d1[K1])), .b($signed(side_s[S_IN].d2[K2])),
			.p(pca[k])
		);
		llca_mul #(.WA(32), .WB(32), .LAT(MUL1_LAT)) u_cb (
			.clk(clk), .en(adv),
			.a($signed(side_s[S_IN].d1[K2])), .b($signed(side_s[S_IN].d2[K1])),
			.p(pcb[k])
		);
		llca_mul #(.WA(33), .WB(32), .LAT(MUL1_LAT)) u_1a (
			.clk(clk), .en(adv),
			.a($signed(side_s[S_IN].w[K1])), .b($signed(side_s[S_IN].d2[K2])),
			.p(p1a[k])
		);
		llca_mul #(.WA(33), .WB(32), .LAT(MUL1_LAT)) u_1b (
			.clk(clk), .en(adv),
			.a($signed(side_s[S_IN].w[K2])), .b($signed(side_s[S_IN].d2[K1])),
			.p(p1b[k])
		);
		llca_mul #(.WA(33), .WB(32), .LAT(MUL1_LAT)) u_2a (
			.clk(clk), .en(adv),
			.a($signed(side_s[S_IN].w[K1])), .b($signed(side_s[S_IN].d1[K2])),
			.p(p2a[k])
		);
		llca_mul #(.WA(33), .WB(32), .LAT(MUL1_LAT)) u_2b (
			.clk(clk), .en(adv),
			.a($signed(side_s[S_IN].w[K2])), .b($signed(side_s[S_IN].d1[K1])),
			.p(p2b[k])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				c_s3[k]  <= 65'(pca[k]) - 65'(pcb[k]);
				t1_s3[k] <= 66'(p1a[k]) - 66'(p1b[k]);
				t2_s3[k] <= 66'(p2a[k]) - 66'(p2b[k]);
			end
		end
	end

	// dot products against c
	for (genvar k = 0; k < 3; k++) begin : g_dot
		llca_mul #(.WA(65), .WB(65), .LAT(MUL2_LAT)) u_den (
			.clk(clk), .en(adv), .a(c_s3[k]), .b(c_s3[k]), .p(pden[k])
		);
		llca_mul #(.WA(66), .WB(65), .LAT(MUL2_LAT)) u_ta (
			.clk(clk), .en(adv), .a(t1_s3[k]), .b(c_s3[k]), .p(pta[k])
		);
		llca_mul #(.WA(66), .WB(65), .LAT(MUL2_LAT)) u_tb (
			.clk(clk), .en(adv), .a(t2_s3[k]), .b(c_s3[k]), .p(ptb[k])
		);
		llca_mul #(.WA(33), .WB(65), .LAT(MUL2_LAT)) u_wc (
			.clk(clk), .en(adv), .a($signed(side_s[S_CROSS].w[k])), .b(c_s3[k]),
			.p(pwc[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s[S_DOT] <= 132'(pden[0]) + 132'(pden[1]) + 132'(pden[2]);
			ta_s7        <= 133'(pta[0]) + 133'(pta[1]) + 133'(pta[2]);
			tb_s7        <= 133'(ptb[0]) + 133'(ptb[1]) + 133'(ptb[2]);
			wc_s7        <= 100'(pwc[0]) + 100'(pwc[1]) + 100'(pwc[2]);
			for (int k = S_DOT; k < S_NUM - 1; k++) begin
				den_s[k+1] <= den_s[k];
			end
		end
	end

	// squared projection and midpoint numerators
	llca_mul #(.WA(100), .WB(100), .LAT(MUL3_LAT)) u_wc2 (
		.clk(clk), .en(adv), .a(wc_s7), .b(wc_s7), .p(pwc2)
	);

	for (genvar k = 0; k < 3; k++) begin : g_num
		llca_mul #(.WA(132), .WB(33), .LAT(MUL3_LAT)) u_b (
			.clk(clk), .en(adv), .a($signed(den_s[S_DOT])),
			.b($signed(side_s[S_DOT].bsum[k])), .p(pb[k])
		);
		llca_mul #(.WA(133), .WB(32), .LAT(MUL3_LAT)) u_d1 (
			.clk(clk), .en(adv), .a(ta_s7), .b($signed(side_s[S_DOT].d1[k])),
			.p(pd1[k])
		);
		llca_mul #(.WA(133), .WB(32), .LAT(MUL3_LAT)) u_d2 (
			.clk(clk), .en(adv), .a(tb_s7), .b($signed(side_s[S_DOT].d2[k])),
			.p(pd2[k])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k]  = 167'(pb[k]) + 167'(pd1[k]) + 167'(pd2[k]);
			absn[k] = num[k][166] ? -num[k] : num[k];
		end
		if (side_s[S_NUM-1].z2) begin
			st_nxt = ST_DIR2_ZERO;
		end else if (side_s[S_NUM-1].z1) begin
			st_nxt = ST_DIR1_ZERO;
		end else if (den_s[S_NUM-1] <= {100'b0, thr_q}) begin
			st_nxt = ST_PARALLEL;
		end else begin
			st_nxt = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nq_s12 <= pwc2[198:0];
			dq_s12 <= den_s[S_NUM-1][130:0];
			dm_s12 <= {den_s[S_NUM-1], 1'b0};
			for (int k = 0; k < 3; k++) begin
				nm_s12[k] <= {1'b0, absn[k]} + {36'b0, den_s[S_NUM-1]};
			end
			tail_s[S_NUM].status <= st_nxt;
			tail_s[S_NUM].neg    <= {num[2][166], num[1][166], num[0][166]};
			for (int k = S_NUM; k < S_FMT; k++) begin
				tail_s[k+1] <= tail_s[k];
			end
		end
	end

	llca_div #(.NW(199), .DW(131), .QW(GAP_QW), .LAT(DIVQ_LAT)) u_divq (
		.clk(clk), .en(adv), .n(nq_s12), .d(dq_s12), .q(q_gap), .sat(sat_gap)
	);

	llca_sqrt u_sqrt (
		.clk(clk), .en(adv), .x(q_gap), .ovf(sat_gap), .root(gap)
	);

	for (genvar k = 0; k < 3; k++) begin : g_mid
		llca_div #(.NW(168), .DW(133), .QW(MID_QW), .LAT(MID_LAT)) u_divm (
			.clk(clk), .en(adv), .n(nm_s12[k]), .d(dm_s12), .q(m_mid[k]),
			.sat(sat_mid[k])
		);

		always_comb begin
			if (!tail_s[S_FMT].neg[k]) begin
				if (!sat_mid[k] && m_mid[k] <= 33'h07FFFFFFF) begin
					mres[k] = m_mid[k][31:0];
				end else begin
					mres[k] = 32'h7FFFFFFF;
				end
			end else if (!sat_mid[k] && m_mid[k] <= 33'h080000000) begin
				mres[k] = 32'd0 - m_mid[k][31:0];
			end else begin
				mres[k] = 32'h80000000;
			end
		end
	end

	always_comb begin
		out_nxt.status = tail_s[S_FMT].status;
		if (tail_s[S_FMT].status == ST_OK) begin
			out_nxt.gap_distance = gap;
			out_nxt.mid_x        = mres[0];
			out_nxt.mid_y        = mres[1];
			out_nxt.mid_z        = mres[2];
		end else begin
			out_nxt.gap_distance = '0;
			out_nxt.mid_x        = '0;
			out_nxt.mid_y        = '0;
			out_nxt.mid_z        = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s110 <= out_nxt;
		end
	end

	// skid: hold a result the consumer refused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_s[S_OUT] && !res_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= out_s110;
		end
	end

	assign res_valid = skid_v_q || vld_s[S_OUT];
	assign res       = skid_v_q ? skid_q : out_s110;

	`LLCA_ASSERT_IMP(a_err_fields_zero, res_valid && res.status != ST_OK, res.gap_distance == '0 && res.mid_x == '0 && res.mid_y == '0 && res.mid_z == '0)
	`LLCA_ASSERT_NEXT(a_stall_holds, skid_v_q && !res_ready, $stable(vld_s) && $stable(skid_q))
	`LLCA_ASSERT_IMP(a_skid_load, $rose(skid_v_q), $past(vld_s[S_OUT] && !res_ready))

endmodule

// ----- hdl/llca_mul.sv -----
// ----------------------------------------------------------------------------
// Closest approach pipelined multiplier
// Signed product built from 33x33 partial products, one B chunk per stage.
// ----------------------------------------------------------------------------
module llca_mul #(
	parameter int WA  = 32,
	parameter int WB  = 32,
	parameter int LAT = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int CW = 32;
	localparam int NA = (WA + CW - 1) / CW;
	localparam int NB = (WB + CW - 1) / CW;
	localparam int WP = WA + WB;

	logic signed [NA*CW-1:0] a_s   [1:LAT];
	logic signed [NB*CW-1:0] b_s   [1:LAT];
	logic signed [WP-1:0]    acc_s [1:LAT];

	for (genvar j = 0; j < LAT; j++) begin : g_stage
		logic signed [NA*CW-1:0] a_cur;
		logic signed [NB*CW-1:0] b_cur;
		logic signed [WP-1:0]    acc_cur;
		logic signed [WP-1:0]    sum;

		if (j == 0) begin : g_first
			assign a_cur   = (NA*CW)'(a);
			assign b_cur   = (NB*CW)'(b);
			assign acc_cur = '0;
		end else begin : g_next
			assign a_cur   = a_s[j];
			assign b_cur   = b_s[j];
			assign acc_cur = acc_s[j];
		end

		if (j < NB) begin : g_mac
			logic signed [CW:0]     ac;
			logic signed [CW:0]     bc;
			logic signed [2*CW+1:0] pr;
			always_comb begin
				if (j == NB - 1) begin
					bc = $signed({b_cur[j*CW+CW-1], b_cur[j*CW +: CW]});
				end else begin
					bc = $signed({1'b0, b_cur[j*CW +: CW]});
				end
				sum = acc_cur;
				ac  = '0;
				pr  = '0;
				for (int i = 0; i < NA; i++) begin
					if (i == NA - 1) begin
						ac = $signed({a_cur[i*CW+CW-1], a_cur[i*CW +: CW]});
					end else begin
						ac = $signed({1'b0, a_cur[i*CW +: CW]});
					end
					pr  = ac * bc;
					sum = sum + (WP'(pr) <<< (CW * (i + j)));
				end
			end
		end else begin : g_pass
			assign sum = acc_cur;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j+1] <= sum;
				a_s[j+1]   <= a_cur;
				b_s[j+1]   <= b_cur;
			end
		end
	end

	assign p = acc_s[LAT];

endmodule

// ----- hdl/llca_div.sv -----
// ----------------------------------------------------------------------------
// Closest approach pipelined divider
// Restoring unsigned division; overflow flag, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module llca_div #(
	parameter int NW  = 64,
	parameter int DW  = 32,
	parameter int QW  = 32,
	parameter int LAT = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [QW-1:0] q,
	output logic          sat
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] r_s   [1:LAT];
	logic [DW-1:0] d_s   [1:LAT];
	logic [QW-1:0] q_s   [1:LAT];
	logic          sat_s [1:LAT];

	for (genvar j = 0; j < LAT; j++) begin : g_stage
		logic [RW-1:0] r_cur;
		logic [RW-1:0] r_nxt;
		logic [DW-1:0] d_cur;
		logic [QW-1:0] q_cur;
		logic [QW-1:0] q_nxt;
		logic          sat_cur;
		logic          sat_nxt;

		if (j == 0) begin : g_first
			assign r_cur   = RW'(n);
			assign d_cur   = d;
			assign q_cur   = '0;
			assign sat_cur = 1'b0;
		end else begin : g_next
			assign r_cur   = r_s[j];
			assign d_cur   = d_s[j];
			assign q_cur   = q_s[j];
			assign sat_cur = sat_s[j];
		end

		if (j == 0) begin : g_ovf
			always_comb begin
				r_nxt   = r_cur;
				q_nxt   = q_cur;
				sat_nxt = r_cur >= (RW'(d_cur) << QW);
			end
		end else if (j <= QW) begin : g_bit
			localparam int B = QW - j;
			logic [RW-1:0] dsh;
			assign dsh = RW'(d_cur) << B;
			always_comb begin
				r_nxt    = r_cur;
				q_nxt    = q_cur;
				sat_nxt  = sat_cur;
				q_nxt[B] = r_cur >= dsh;
				if (r_cur >= dsh) begin
					r_nxt = r_cur - dsh;
				end
			end
		end else begin : g_pass
			assign r_nxt   = r_cur;
			assign q_nxt   = q_cur;
			assign sat_nxt = sat_cur;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j+1]   <= r_nxt;
				d_s[j+1]   <= d_cur;
				q_s[j+1]   <= q_nxt;
				sat_s[j+1] <= sat_nxt;
			end
		end
	end

	assign q   = q_s[LAT];
	assign sat = sat_s[LAT];

endmodule

// ----- hdl/llca_sqrt.sv -----
// ----------------------------------------------------------------------------
// Closest approach pipelined square root
// Floor square root of a 64-bit value, one root bit per stage, saturating.
// ----------------------------------------------------------------------------
module llca_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] x,
	input  logic        ovf,
	output logic [31:0] root
);

	import llca_pkg::*;

	logic [63:0] rem_s [1:SQRT_LAT];
	logic [31:0] r_s   [1:SQRT_LAT];
	logic        o_s   [1:SQRT_LAT];

	for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
		localparam int B = SQRT_LAT - 1 - j;
		logic [63:0] rem_cur;
		logic [63:0] rem_nxt;
		logic [31:0] r_cur;
		logic [31:0] r_nxt;
		logic        o_cur;
		logic [65:0] inc;

		if (j == 0) begin : g_first
			assign rem_cur = x;
			assign r_cur   = '0;
			assign o_cur   = ovf;
		end else begin : g_next
			assign rem_cur = rem_s[j];
			assign r_cur   = r_s[j];
			assign o_cur   = o_s[j];
		end

		assign inc = (66'(r_cur) << (B + 1)) + (66'(1) << (2 * B));

		always_comb begin
			rem_nxt = rem_cur;
			r_nxt   = r_cur;
			if (66'(rem_cur) >= inc) begin
				rem_nxt  = rem_cur - inc[63:0];
				r_nxt[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= rem_nxt;
				r_s[j+1]   <= r_nxt;
				o_s[j+1]   <= o_cur;
			end
		end
	end

	assign root = o_s[SQRT_LAT] ? '1 : r_s[SQRT_LAT];

endmodule

// ----- bench/tb_line_line_closest_approach_3d.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest approach testbench
// Drives line pairs through the valid/ready request channel with random gaps
// and result stalls. Expected distance, midpoint and status come from a
// wide-integer predictor and are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_line_line_closest_approach_3d;
	import llca_pkg::*;

	typedef logic signed [255:0] wide_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        cfg_wen;
	logic [31:0] cfg_wdata;

	res_t        expected_q[$];
	logic [31:0] threshold;
	int          errors;
	bit          sending;
	int          hold_cnt;

	line_line_closest_approach_3d uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#100ms;
		$display("tb_line_line_closest_approach_3d: FAIL");
		$finish;
	end

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic res_t closest_points(req_t q, logic [31:0] thr);
		res_t  o;
		wide_t b1[3], d1[3], b2[3], d2[3], w[3], c[3], t[3];
		wide_t den, ta, tb, wc, num, m;
		logic [255:0] qd, anum;
		bit    z1, z2;
		o = '0;
		b1[0] = q.first_base_x;  b1[1] = q.first_base_y;  b1[2] = q.first_base_z;
		d1[0] = q.first_dir_x;   d1[1] = q.first_dir_y;   d1[2] = q.first_dir_z;
		b2[0] = q.second_base_x; b2[1] = q.second_base_y; b2[2] = q.second_base_z;
		d2[0] = q.second_dir_x;  d2[1] = q.second_dir_y;  d2[2] = q.second_dir_z;
		z1 = (d1[0] == 0) && (d1[1] == 0) && (d1[2] == 0);
		z2 = (d2[0] == 0) && (d2[1] == 0) && (d2[2] == 0);
		for (int k = 0; k < 3; k++) w[k] = b2[k] - b1[k];
		if (z2) begin
			o.status = ST_DIR2_ZERO;
			return o;
		end
		if (z1) begin
			o.status = ST_DIR1_ZERO;
			return o;
		end
		c[0] = d1[1] * d2[2] - d1[2] * d2[1];
		c[1] = d1[2] * d2[0] - d1[0] * d2[2];
		c[2] = d1[0] * d2[1] - d1[1] * d2[0];
		den = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		if (den <= $signed({224'd0, thr})) begin
			o.status = ST_PARALLEL;
			return o;
		end
		t[0] = w[1] * d2[2] - w[2] * d2[1];
		t[1] = w[2] * d2[0] - w[0] * d2[2];
		t[2] = w[0] * d2[1] - w[1] * d2[0];
		ta = t[0] * c[0] + t[1] * c[1] + t[2] * c[2];
		t[0] = w[1] * d1[2] - w[2] * d1[1];
		t[1] = w[2] * d1[0] - w[0] * d1[2];
		t[2] = w[0] * d1[1] - w[1] * d1[0];
		tb = t[0] * c[0] + t[1] * c[1] + t[2] * c[2];
		wc = w[0] * c[0] + w[1] * c[1] + w[2] * c[2];
		qd = $unsigned(wc * wc) / $unsigned(den);
		o.status = ST_OK;
		if (qd[255:64] != 0)
			o.gap_distance = 32'hFFFF_FFFF;
		else
			o.gap_distance = 32'(root64(qd[63:0]));
		for (int k = 0; k < 3; k++) begin
			num = (b1[k] + b2[k]) * den + d1[k] * ta + d2[k] * tb;
			anum = num < 0 ? -num : num;
			m = (anum + $unsigned(den)) / $unsigned(den + den);
			if (num >= 0)
				o[95 - 32 * k -: 32] = (m <= 256'h7FFF_FFFF) ? m[31:0] : 32'h7FFF_FFFF;
			else
				o[95 - 32 * k -: 32] = (m <= 256'h8000_0000) ? -m[31:0] : 32'h8000_0000;
		end
		return o;
	endfunction

	// result side: random stalls, compare against oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result %h", res);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (res.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, res.status); errors++;
					end
					if (res.gap_distance !== e.gap_distance) begin
						$error("gap_distance exp %h got %h", e.gap_distance, res.gap_distance);
						errors++;
					end
					if (res.mid_x !== e.mid_x) begin
						$error("mid_x exp %h got %h", e.mid_x, res.mid_x); errors++;
					end
					if (res.mid_y !== e.mid_y) begin
						$error("mid_y exp %h got %h", e.mid_y, res.mid_y); errors++;
					end
					if (res.mid_z !== e.mid_z) begin
						$error("mid_z exp %h got %h", e.mid_z, res.mid_z); errors++;
					end
				end
				hold_cnt = $urandom_range(0, 3);
			end
			if (!sending || hold_cnt == 0) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b0;
				hold_cnt--;
			end
		end
	end

	task automatic send_pair(req_t q);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= q;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_q.push_back(closest_points(q, threshold));
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_threshold(logic [31:0] v);
		drain();
		repeat (MID_LAT + 20) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		threshold = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			2: return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $signed($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	function automatic req_t rnd_pair(int mode);
		req_t q;
		for (int i = 0; i < 12; i++) q[i * 32 +: 32] = rnd_coord($urandom_range(0, 3) == 0 ? 0 : mode);
		if ($urandom_range(0, 40) == 0) {q.first_dir_x, q.first_dir_y, q.first_dir_z} = '0;
		if ($urandom_range(0, 40) == 0) {q.second_dir_x, q.second_dir_y, q.second_dir_z} = '0;
		if ($urandom_range(0, 20) == 0) begin
			q.second_dir_x = q.first_dir_x;
			q.second_dir_y = q.first_dir_y;
			q.second_dir_z = q.first_dir_z;
		end
		return q;
	endfunction

	task automatic test_special_cases;
		req_t q;
		q = '0;
		q.first_dir_x = 32'h0001_0000;
		send_pair(q);
		q.second_dir_y = 32'h0001_0000;
		q.second_base_z = 32'h0003_0000;
		send_pair(q);
		q.first_dir_x = 0;
		send_pair(q);
		q = '0;
		q.first_dir_x = 32'h0001_0000; q.second_dir_x = 32'h0002_0000;
		send_pair(q);
		q = '1;
		send_pair(q);
		q = {12{32'h8000_0000}};
		q.second_dir_y = 32'h7FFF_FFFF;
		send_pair(q);
		q = {12{32'h7FFF_FFFF}};
		q.first_dir_z = 32'h8000_0000;
		send_pair(q);
		q = '0;
		q.first_dir_x = 1; q.second_dir_y = 1;
		q.first_base_x = 32'h7FFF_FFFF; q.second_base_x = 32'h7FFF_FFFF;
		q.second_base_z = 32'h8000_0000;
		send_pair(q);
		q = '0;
		q.first_dir_x = 1; q.second_dir_y = 1; q.second_base_z = 3;
		q.second_base_x = 1;
		send_pair(q);
		for (int i = 0; i < 8; i++) send_pair(rnd_pair(2));
	endtask

	task automatic test_threshold_levels;
		req_t q;
		set_threshold(32'hFFFF_FFFF);
		q = '0;
		q.first_dir_x = 32'h0000_0100; q.second_dir_y = 32'h0000_0100;
		send_pair(q);
		q.first_dir_x = 32'h0001_0000; q.second_dir_y = 32'h0001_0000;
		send_pair(q);
		for (int i = 0; i < 40; i++) send_pair(rnd_pair(3));
		set_threshold(32'd1);
		for (int i = 0; i < 40; i++) send_pair(rnd_pair(3));
		set_threshold(32'h0000_1000);
	endtask

	task automatic test_random_pairs;
		for (int i = 0; i < 700; i++) begin
			send_pair(rnd_pair($urandom_range(0, 3)));
			if (i == 350) set_threshold(32'd0);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		res_ready = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		threshold = '0;
		errors    = 0;
		hold_cnt  = 0;
		sending   = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_threshold_levels();
		test_random_pairs();
		sending = 1'b0;
		drain();
		repeat (MID_LAT + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_line_line_closest_approach_3d: PASS");
		else
			$display("tb_line_line_closest_approach_3d: FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/llca_pkg.sv
hdl/llca_mul.sv
hdl/llca_div.sv
hdl/llca_sqrt.sv
hdl/line_line_closest_approach_3d.sv
bench/tb_line_line_closest_approach_3d.sv
